// ----- rtl/prob_pkg.sv -----
// shared types and constants for the pixel raster op and blend pipeline
// no dependencies; imported by every prob_* module and the top level
package prob_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned MODE_W  = 5;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned ACC_W   = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;

    // extended modes; codes below MODE_HIGHLIGHT are bitwise logic ops
    localparam logic [MODE_W-1:0] MODE_HIGHLIGHT = 5'd16;
    localparam logic [MODE_W-1:0] MODE_OVER      = 5'd17;
    localparam logic [MODE_W-1:0] MODE_ADD_MAX   = 5'd18;
    localparam logic [MODE_W-1:0] MODE_SUB_MIN   = 5'd19;
    localparam logic [MODE_W-1:0] MODE_BLEND     = 5'd20;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HIGHLIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_FLOOR     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_CEILING   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_WEIGHT    = 3'd4;

    // register reset values
    localparam logic [MODE_W-1:0] MODE_RESET    = 5'd3;
    localparam logic [RGB_W-1:0]  CEILING_RESET = 24'hFFFFFF;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [RGB_W-1:0]  highlight;
        logic [RGB_W-1:0]  floor_rgb;
        logic [RGB_W-1:0]  ceiling;
        logic [RGB_W-1:0]  weight;
    } cfg_t;

    // channel 0 is red
    typedef struct packed {
        logic [NUM_CH-1:0][CHAN_W-1:0] a;
        logic [NUM_CH-1:0][CHAN_W-1:0] b;
        logic [NUM_CH-1:0][CHAN_W-1:0] w;
        logic                          use_mix;
        logic [PIX_W-1:0]              direct;
    } front_t;

    typedef struct packed {
        logic [NUM_CH-1:0][ACC_W-1:0] acc;
        logic                         use_mix;
        logic [PIX_W-1:0]             direct;
    } mac_t;

endpackage

// ----- rtl/prob_front.sv -----
// first stage: operand selection, logic ops, highlight and clamped add/subtract
// depends on prob_pkg
module prob_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  prob_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     src,
    input  logic [31:0]     dst,
    output logic            out_valid,
    input  logic            out_ready,
    output prob_pkg::front_t out_data
);
    import prob_pkg::*;

    logic   valid_reg, valid_next;
    front_t data_reg, data_next;

    always_comb begin
        logic [CHAN_W-1:0] sc, dc, top, low, diff;
        logic [CHAN_W:0]   sum;
        logic [RGB_W-1:0]  lrgb, add_rgb, sub_rgb;
        logic [3:0]        code;
        front_t            f;
        code = cfg.mode[3:0];
        for (int i = 0; i < RGB_W; i++) begin
            lrgb[i] = code[{~src[i+CHAN_W], ~dst[i+CHAN_W]}];
        end
        for (int c = 0; c < NUM_CH; c++) begin
            sc   = src[PIX_W-1-CHAN_W*c -: CHAN_W];
            dc   = dst[PIX_W-1-CHAN_W*c -: CHAN_W];
            top  = cfg.ceiling[RGB_W-1-CHAN_W*c -: CHAN_W];
            low  = cfg.floor_rgb[RGB_W-1-CHAN_W*c -: CHAN_W];
            sum  = {1'b0, sc} + {1'b0, dc};
            diff = dc - sc;
            add_rgb[RGB_W-1-CHAN_W*c -: CHAN_W] = (sum > {1'b0, top}) ? top : sum[CHAN_W-1:0];
            sub_rgb[RGB_W-1-CHAN_W*c -: CHAN_W] = (dc < sc || diff < low) ? low : diff;
            f.a[c] = sc;
            f.b[c] = dc;
            f.w[c] = (cfg.mode == MODE_OVER) ? src[CHAN_W-1:0]
                                             : cfg.weight[RGB_W-1-CHAN_W*c -: CHAN_W];
        end
        f.use_mix = 1'b0;
        f.direct  = dst;
        priority if (cfg.mode < MODE_HIGHLIGHT) begin
            f.direct = {lrgb, ALPHA_OPAQUE};
        end else if (cfg.mode == MODE_HIGHLIGHT) begin
            f.direct = (|src[PIX_W-1:CHAN_W]) ? {cfg.highlight, ALPHA_OPAQUE} : dst;
        end else if (cfg.mode == MODE_OVER) begin
            // transparent source keeps the destination, alpha included
            f.use_mix = (src[CHAN_W-1:0] != '0);
        end else if (cfg.mode == MODE_ADD_MAX) begin
            f.direct = {add_rgb, ALPHA_OPAQUE};
        end else if (cfg.mode == MODE_SUB_MIN) begin
            f.direct = {sub_rgb, ALPHA_OPAQUE};
        end else begin
            f.use_mix = 1'b1;
        end
        data_next = f;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/prob_mac.sv -----
// second stage: per-channel weighted sum a*w + b*(255-w)
// depends on prob_pkg
module prob_mac (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  prob_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output prob_pkg::mac_t   out_data
);
    import prob_pkg::*;

    logic valid_reg, valid_next;
    mac_t data_reg, data_next;

    always_comb begin
        logic [ACC_W-1:0] pa, pb;
        for (int c = 0; c < NUM_CH; c++) begin
            pa = {{CHAN_W{1'b0}}, in_data.a[c]} * {{CHAN_W{1'b0}}, in_data.w[c]};
            pb = {{CHAN_W{1'b0}}, in_data.b[c]} * {{CHAN_W{1'b0}}, CHAN_MAX - in_data.w[c]};
            data_next.acc[c] = pa + pb;
        end
        data_next.use_mix = in_data.use_mix;
        data_next.direct  = in_data.direct;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/prob_div.sv -----
// third stage: divide by 255 with truncation, pack and select, output register
// depends on prob_pkg
module prob_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  prob_pkg::mac_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    out_pixel
);
    import prob_pkg::*;

    logic             valid_reg, valid_next;
    logic [PIX_W-1:0] pixel_reg, pixel_next;

    always_comb begin
        logic [ACC_W-1:0]  x, q;
        logic [RGB_W-1:0]  rgb;
        for (int c = 0; c < NUM_CH; c++) begin
            x = in_data.acc[c];
            // exact floor(x / 255) for x up to 255 * 255
            q = (x + (x >> CHAN_W) + ACC_W'(1)) >> CHAN_W;
            rgb[RGB_W-1-CHAN_W*c -: CHAN_W] = q[CHAN_W-1:0];
        end
        pixel_next = in_data.use_mix ? {rgb, ALPHA_OPAQUE} : in_data.direct;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ----- rtl/pixel_raster_op_blend.sv -----
// top level of the pixel raster op and blend pipeline: config registers and stages
// depends on prob_pkg, prob_front, prob_mac, prob_div
//
//  channel | ports                                  | transfer when
//  --------+----------------------------------------+----------------------
//  input   | s_valid s_ready s_source_pixel s_dest_pixel | s_valid && s_ready
//  output  | m_valid m_ready m_result_pixel         | m_valid && m_ready
//  config  | cfg_wr_en cfg_index cfg_wdata          | cfg_wr_en
//
// three register stages (operand select, multiply-add, divide by 255 and pack)
// one pixel per clock while the sink keeps m_ready high; each pixel passes the front,
// mac and div stage registers in that order before m_valid rises for it
// each stage holds its item while the next one stalls; nothing is dropped
// synchronous active-low reset clears stage valids and loads the config registers with their reset values
module pixel_raster_op_blend (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_source_pixel,
    input  logic [31:0] s_dest_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_pixel,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import prob_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   front_valid, front_ready;
    front_t front_data;
    logic   mac_valid, mac_ready;
    mac_t   mac_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_wdata[MODE_W-1:0];
                CFG_HIGHLIGHT: cfg_next.highlight = cfg_wdata;
                CFG_FLOOR:     cfg_next.floor_rgb = cfg_wdata;
                CFG_CEILING:   cfg_next.ceiling   = cfg_wdata;
                CFG_WEIGHT:    cfg_next.weight    = cfg_wdata;
                default:       cfg_next           = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode      <= MODE_RESET;
            cfg_reg.highlight <= '0;
            cfg_reg.floor_rgb <= '0;
            cfg_reg.ceiling   <= CEILING_RESET;
            cfg_reg.weight    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    prob_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .src       (s_source_pixel),
        .dst       (s_dest_pixel),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    prob_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_data  (mac_data)
    );

    prob_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mac_valid),
        .in_ready  (mac_ready),
        .in_data   (mac_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (m_result_pixel)
    );

    // a stalled first stage keeps its item
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        front_valid && !front_ready |=> front_valid && $stable(front_data))
        else $error("first stage item changed while stalled");

    // a stalled middle stage keeps its item
    a_mac_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_valid && !mac_ready |=> mac_valid && $stable(mac_data))
        else $error("middle stage item changed while stalled");

    // mode write lands in the register
    a_mode_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en && cfg_index == CFG_MODE |=> cfg_reg.mode == $past(cfg_wdata[MODE_W-1:0]))
        else $error("mode register write lost");

    // pipeline empty straight after reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid && !front_valid && !mac_valid)
        else $error("stage valid set after reset");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for pixel_raster_op_blend: directed table, then random pixels
// depends on prob_pkg and the pixel_raster_op_blend rtl; predicts each result pixel itself
`timescale 1ns / 1ps

module tb_top;
    import prob_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_TAIL     = 8;
    localparam int PHASE_PIXELS   = 317;
    localparam logic [IDX_W-1:0]  CFG_UNUSED = 3'd7;
    localparam logic [MODE_W-1:0] MODE_TOP   = 5'd31;

    typedef enum logic [3:0] {
        ROP_CLEAR, ROP_AND, ROP_AND_INV, ROP_COPY, ROP_AND_NOT_SRC, ROP_NOOP,
        ROP_XOR, ROP_OR, ROP_NOR, ROP_XNOR, ROP_INV_DST, ROP_OR_INV,
        ROP_COPY_INV, ROP_OR_NOT_SRC, ROP_NAND, ROP_SET
    } rop_e;

    typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_e;

    typedef struct packed {
        step_kind_e       kind;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] data;
        logic [31:0]      src;
        logic [31:0]      dst;
        logic             known;
        logic [31:0]      want;
    } plan_row_t;

    localparam int PLAN_LEN = 34;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h000000FF},
        '{STEP_WRITE, CFG_MODE, 24'(ROP_CLEAR), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h000000FF},
        '{STEP_WRITE, CFG_MODE, 24'(ROP_SET), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
        '{STEP_WRITE, CFG_MODE, 24'(ROP_XOR), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hA5A5A5A5, 32'h0F0F0F0F, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(ROP_NAND), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h12345678, 32'hFFFFFFFF, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_HIGHLIGHT, 24'h123456, 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_HIGHLIGHT), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h000000AB, 32'hDEADBEEF, 1'b1, 32'hDEADBEEF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h00000100, 32'h00000000, 1'b1, 32'h123456FF},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_OVER), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFF00, 32'h11223344, 1'b1, 32'h11223344},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h808080FF, 32'h11223344, 1'b1, 32'h808080FF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFF000080, 32'h00FF0040, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_CEILING, 24'h804020, 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_ADD_MAX), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFF00, 32'hFFFFFF00, 1'b1, 32'h804020FF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h01020300, 32'h10101000, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_FLOOR, 24'h102030, 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_SUB_MIN), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h102030FF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h01020300, 32'h80808000, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_WEIGHT, 24'hFF0080, 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_BLEND), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'hFFFFFF00, 32'h00000000, 1'b1, 32'hFF0080FF},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_MODE, 24'(MODE_TOP), 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0},
        '{STEP_WRITE, CFG_UNUSED, 24'h000003, 32'h0, 32'h0, 1'b0, 32'h0},
        '{STEP_PIXEL, CFG_MODE, 24'h0, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [31:0]       s_source_pixel = '0;
    logic [31:0]       s_dest_pixel = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [31:0]       m_result_pixel;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [RGB_W-1:0]  cfg_wdata = '0;

    // register mirror
    logic [MODE_W-1:0] mode_q = MODE_RESET;
    logic [RGB_W-1:0]  hilite_q = '0;
    logic [RGB_W-1:0]  floor_q = '0;
    logic [RGB_W-1:0]  ceil_q = CEILING_RESET;
    logic [RGB_W-1:0]  weight_q = '0;

    logic [31:0] pixel_due [$];
    int src_idle_pct = 37;
    int sink_idle_pct = 72;
    int stall_cycles = 0;
    int error_count = 0;
    int pixels_sent = 0;
    int results_seen = 0;
    int settings_used = 1;

    pixel_raster_op_blend u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_source_pixel (s_source_pixel),
        .s_dest_pixel   (s_dest_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_pixel (m_result_pixel),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [7:0] weigh(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] w);
        return 8'((int'(a) * int'(w) + int'(b) * (int'(CHAN_MAX) - int'(w)))
                  / int'(CHAN_MAX));
    endfunction

    function automatic logic [31:0] rop_result(input logic [31:0] src, input logic [31:0] dst);
        logic [23:0] ss, ds, rgb;
        logic [7:0]  sc, dc, lim, a;
        int          k;
        ss = src[31:8];
        ds = dst[31:8];
        a  = src[7:0];
        rgb = '0;
        if (mode_q < MODE_HIGHLIGHT) begin
            case (rop_e'(mode_q[3:0]))
                ROP_CLEAR:       rgb = '0;
                ROP_AND:         rgb = ss & ds;
                ROP_AND_INV:     rgb = ss & ~ds;
                ROP_COPY:        rgb = ss;
                ROP_AND_NOT_SRC: rgb = ~ss & ds;
                ROP_NOOP:        rgb = ds;
                ROP_XOR:         rgb = ss ^ ds;
                ROP_OR:          rgb = ss | ds;
                ROP_NOR:         rgb = ~(ss | ds);
                ROP_XNOR:        rgb = ~(ss ^ ds);
                ROP_INV_DST:     rgb = ~ds;
                ROP_OR_INV:      rgb = ss | ~ds;
                ROP_COPY_INV:    rgb = ~ss;
                ROP_OR_NOT_SRC:  rgb = ~ss | ds;
                ROP_NAND:        rgb = ~(ss & ds);
                default:         rgb = '1;
            endcase
            return {rgb, ALPHA_OPAQUE};
        end
        if (mode_q == MODE_HIGHLIGHT)
            return (ss != '0) ? {hilite_q, ALPHA_OPAQUE} : dst;
        if (mode_q == MODE_OVER && a == '0)
            return dst;
        if (mode_q == MODE_OVER && a == CHAN_MAX)
            return {ss, ALPHA_OPAQUE};
        for (k = 0; k < 3; k++) begin
            sc = src[31 - 8*k -: 8];
            dc = dst[31 - 8*k -: 8];
            case (mode_q)
                MODE_OVER: rgb[23 - 8*k -: 8] = weigh(sc, dc, a);
                MODE_ADD_MAX: begin
                    lim = ceil_q[23 - 8*k -: 8];
                    rgb[23 - 8*k -: 8] = (9'(sc) + 9'(dc) > 9'(lim)) ? lim : sc + dc;
                end
                MODE_SUB_MIN: begin
                    lim = floor_q[23 - 8*k -: 8];
                    rgb[23 - 8*k -: 8] = (dc < sc || dc - sc < lim) ? lim : dc - sc;
                end
                default: rgb[23 - 8*k -: 8] = weigh(sc, dc, weight_q[23 - 8*k -: 8]);
            endcase
        end
        return {rgb, ALPHA_OPAQUE};
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_MODE:      mode_q = data[MODE_W-1:0];
            CFG_HIGHLIGHT: hilite_q = data;
            CFG_FLOOR:     floor_q = data;
            CFG_CEILING:   ceil_q = data;
            CFG_WEIGHT:    weight_q = data;
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst,
                              input logic known, input logic [31:0] want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_source_pixel <= src;
        s_dest_pixel   <= dst;
        do @(posedge aclk); while (!s_ready);
        pixel_due.push_back(known ? want : rop_result(src, dst));
        pixels_sent++;
    endtask

    task automatic drain_pixels();
        s_valid <= 1'b0;
        while (pixel_due.size() != 0)
            @(posedge aclk);
    endtask

    // result checking, sink stalls and stall counting
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            stall_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pixel_due.size() == 0) begin
                    $error("result_pixel: unexpected transfer %08h", m_result_pixel);
                    error_count++;
                end else if (m_result_pixel !== pixel_due[0]) begin
                    $error("result_pixel: expected %08h, got %08h", pixel_due[0],
                           m_result_pixel);
                    error_count++;
                    void'(pixel_due.pop_front());
                end else begin
                    void'(pixel_due.pop_front());
                end
            end
            if ((m_valid && m_ready) || (s_valid && s_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pixel_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [31:0]       src, dst;
        logic [RGB_W-1:0]  data;
        logic [MODE_W-1:0] pick;
        int                burst, phase_sent;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == STEP_WRITE) begin
                drain_pixels();
                write_reg(PLAN[i].idx, PLAN[i].data);
                settings_used++;
            end else begin
                send_pixel(PLAN[i].src, PLAN[i].dst, PLAN[i].known, PLAN[i].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct  = (phase == 0) ? 37 : (phase == 1) ? 72 : 0;
            sink_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 37 : 0;
            phase_sent = 0;
            while (phase_sent < PHASE_PIXELS) begin
                drain_pixels();
                // extended modes more often than logic ops
                pick = $urandom_range(1) ? 5'($urandom_range(31))
                                         : 5'($urandom_range(MODE_HIGHLIGHT, MODE_BLEND));
                data = 24'($urandom);
                data[MODE_W-1:0] = pick;
                write_reg(CFG_MODE, data);
                for (int r = CFG_HIGHLIGHT; r <= CFG_WEIGHT; r++) begin
                    if ($urandom_range(2) == 0) begin
                        case ($urandom_range(3))
                            0:       data = '0;
                            1:       data = '1;
                            default: data = 24'($urandom);
                        endcase
                        write_reg(IDX_W'(r), data);
                    end
                end
                if ($urandom_range(7) == 0)
                    write_reg(IDX_W'($urandom_range(CFG_WEIGHT + 1, CFG_UNUSED)),
                              24'($urandom));
                settings_used++;
                burst = $urandom_range(16, 48);
                if (burst > PHASE_PIXELS - phase_sent)
                    burst = PHASE_PIXELS - phase_sent;
                repeat (burst) begin
                    src = $urandom;
                    dst = $urandom;
                    case ($urandom_range(9))
                        0: src[7:0] = '0;
                        1: src[7:0] = CHAN_MAX;
                        2: src[31:8] = '0;
                        3: src = $urandom_range(1) ? '1 : '0;
                        4: dst = $urandom_range(1) ? '1 : '0;
                        default: ;
                    endcase
                    send_pixel(src, dst, 1'b0, '0);
                    phase_sent++;
                end
            end
        end

        drain_pixels();
        repeat (DRAIN_TAIL) @(posedge aclk);
        $display("checked %0d of %0d pixels across %0d register settings",
                 results_seen, pixels_sent, settings_used);
        $display("all mode codes reachable, three sender and sink stall patterns");
        if (error_count == 0 && pixel_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
